// File: rtl/time_window_arc_pruner_top_assert.svh
// Assertion macros used by the arc pruner top level
`ifndef TIME_WINDOW_ARC_PRUNER_TOP_ASSERT_SVH
`define TIME_WINDOW_ARC_PRUNER_TOP_ASSERT_SVH

// same-cycle implication, reset masks the check
`define TWAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, reset masks the check
`define TWAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/twap_pkg.sv
// Shared types and codes of the arc pruner
package twap_pkg;

	localparam int TICK_W     = 24;
	localparam int IDX_W      = 6;
	localparam int ACT_W      = 2;
	localparam int VERD_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int CNT_W      = 7;

	// action codes
	localparam logic [ACT_W-1:0] ACT_LOAD_NODE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_DIST = 2'd1;
	localparam logic [ACT_W-1:0] ACT_EVAL      = 2'd2;

	// verdict codes
	localparam logic [VERD_W-1:0] VERD_KEPT    = 3'd0;
	localparam logic [VERD_W-1:0] VERD_EXCL    = 3'd1;
	localparam logic [VERD_W-1:0] VERD_LATE    = 3'd2;
	localparam logic [VERD_W-1:0] VERD_NORET   = 3'd3;
	localparam logic [VERD_W-1:0] VERD_PRUNED  = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SINK       = 2'd2;

	// register reset values
	localparam logic [CNT_W-1:0] RST_NODE_COUNT = 7'd64;
	localparam logic [IDX_W-1:0] RST_SOURCE     = 6'd0;
	localparam logic [IDX_W-1:0] RST_SINK       = 6'd1;

	// outcome of testing one intermediate node
	typedef struct packed {
		logic prune;
		logic detour;
	} kchk_t;

endpackage

// File: rtl/twap_if.sv
// Channel interfaces: request, result and configuration write
interface twap_req_if;
	logic                          valid;
	logic                          ready;
	logic [twap_pkg::ACT_W-1:0]    action;
	logic [twap_pkg::IDX_W-1:0]    from_index;
	logic [twap_pkg::IDX_W-1:0]    to_index;
	logic [twap_pkg::TICK_W-1:0]   window_open;
	logic [twap_pkg::TICK_W-1:0]   window_close;
	logic [twap_pkg::TICK_W-1:0]   service_ticks;
	logic [twap_pkg::TICK_W-1:0]   travel_ticks;

	modport source (output valid, action, from_index, to_index, window_open, window_close,
		service_ticks, travel_ticks, input ready);
	modport sink (input valid, action, from_index, to_index, window_open, window_close,
		service_ticks, travel_ticks, output ready);
endinterface

interface twap_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          record_kind;
	logic [twap_pkg::IDX_W-1:0]    arc_tail;
	logic [twap_pkg::IDX_W-1:0]    arc_head;
	logic [twap_pkg::VERD_W-1:0]   verdict;
	logic [twap_pkg::TICK_W-1:0]   arc_travel;
	logic [twap_pkg::IDX_W-1:0]    detour_node;
	logic [twap_pkg::TICK_W-1:0]   detour_latest_start;
	logic                          last_record;

	modport source (output valid, record_kind, arc_tail, arc_head, verdict, arc_travel,
		detour_node, detour_latest_start, last_record, input ready);
	modport sink (input valid, record_kind, arc_tail, arc_head, verdict, arc_travel,
		detour_node, detour_latest_start, last_record, output ready);
endinterface

interface twap_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [twap_pkg::CFG_IDX_W-1:0]    index;
	logic [twap_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/twap_ram.sv
// Generic simple dual-port RAM with registered read
module twap_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: rtl/twap_check.sv
// Prune and detour test for one intermediate node k
module twap_check #(
	parameter int TIME_BITS = 24
) (
	input  logic [TIME_BITS-1:0] oi,
	input  logic [TIME_BITS-1:0] ci,
	input  logic [TIME_BITS-1:0] si,
	input  logic [TIME_BITS:0]   cisi,
	input  logic [TIME_BITS-1:0] oj,
	input  logic [TIME_BITS-1:0] ok,
	input  logic [TIME_BITS-1:0] ck,
	input  logic [TIME_BITS-1:0] sk,
	input  logic [TIME_BITS-1:0] dik,
	input  logic [TIME_BITS-1:0] dkj,
	output twap_pkg::kchk_t      chk,
	output logic [TIME_BITS-1:0] latest
);
	localparam int W = TIME_BITS + 4;

	logic signed [W-1:0] ak, reach, lkj_raw, lkj, lik_raw, lik;

	function automatic logic signed [W-1:0] sx(input logic [TIME_BITS-1:0] v);
		return $signed({4'b0000, v});
	endfunction

	// arrival at k, i served from its close; reach of j via k; the two tests
	always_comb begin
		ak      = $signed({3'b000, cisi}) + sx(dik);
		reach   = ((ak >= sx(ok)) ? ak : sx(ok)) + sx(sk) + sx(dkj);
		lkj_raw = sx(oj) - sx(dkj) - sx(sk);
		lkj     = (lkj_raw < sx(ck)) ? lkj_raw : sx(ck);
		lik_raw = lkj - sx(dik) - sx(si);
		lik     = (lik_raw < sx(ci)) ? lik_raw : sx(ci);
		chk.prune  = (ak <= sx(ck)) && (reach <= sx(oj));
		chk.detour = (lkj >= sx(ok)) && (lik >= sx(oi));
		latest     = lik[TIME_BITS-1:0];
	end
endmodule

// File: rtl/time_window_arc_pruner_top.sv
// Top level: arc pruner sequencer over node and distance memories
//
//  channel | role   | moves
//  req     | sink   | load node times, load distance, evaluate arc
//  rsp     | source | verdict item, then detour items in increasing k
//  cfg     | sink   | node_count, source_node, sink_node writes
//
// Loads write the memories on accept. An excluded arc is answered from state S_EXC.
// A full evaluation of n active nodes makes up to two scans over k, with three
// memory reads per visited node.
// Reset acts only on control and configuration; memories hold until written.
// A stalled result item holds the sequencer at its next emit point.
`include "time_window_arc_pruner_top_assert.svh"

module time_window_arc_pruner_top #(
	parameter int NODES     = 64,
	parameter int TIME_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	twap_req_if.sink   req,
	twap_rsp_if.source rsp,
	twap_cfg_if.sink   cfg
);
	localparam int IW  = $clog2(NODES);
	localparam int DAW = $clog2(NODES * NODES);
	localparam int KW  = $clog2(NODES + 1);
	localparam int XW  = twap_pkg::IDX_W + 1;
	localparam int T   = TIME_BITS;
	localparam int W   = TIME_BITS + 4;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_EXC    = 10'b0000000010,
		S_RD_I   = 10'b0000000100,
		S_RD_J   = 10'b0000001000,
		S_RD_S   = 10'b0000010000,
		S_CHK    = 10'b0000100000,
		S_K_ISS  = 10'b0001000000,
		S_K_MID  = 10'b0010000000,
		S_K_EVAL = 10'b0100000000,
		S_VERD   = 10'b1000000000
	} state_t;

	function automatic logic signed [W-1:0] sx(input logic [T-1:0] v);
		return $signed({4'b0000, v});
	endfunction

	function automatic logic [DAW-1:0] daddr(input logic [IW-1:0] a, input logic [IW-1:0] b);
		return DAW'(a) * DAW'(NODES) + DAW'(b);
	endfunction

	state_t state_q, state_d;

	logic [twap_pkg::CNT_W-1:0] ncnt_q;
	logic [twap_pkg::IDX_W-1:0] src_q, snk_q;
	logic [XW-1:0]              n_act;

	logic [twap_pkg::IDX_W-1:0] tail_q, head_q;
	logic [T-1:0] oi_q, ci_q, si_q, oj_q, cj_q, sj_q, dij_q, djs_q;
	logic [T-1:0] ok_q, ck_q, sk_q, dik_q;
	logic [T:0]   cisi_q;
	logic signed [W-1:0] arrj_q, ret;
	logic [KW-1:0] k_q, ndet_q, nemit_q;
	logic          pass_q;

	// result register
	logic                        ovalid_q, okind_q, olast_q;
	logic [twap_pkg::VERD_W-1:0] overd_q;
	logic [twap_pkg::TICK_W-1:0] otravel_q, olate_q;
	logic [twap_pkg::IDX_W-1:0]  onode_q, otail_q, ohead_q;

	// memory ports
	logic           node_we, node_re, dist_we, dist_re;
	logic [IW-1:0]  node_waddr, node_raddr;
	logic [DAW-1:0] dist_waddr, dist_raddr;
	logic [3*T-1:0] node_wdata, node_rdata;
	logic [T-1:0]   dist_rdata, tmax;

	logic req_acc, eval_acc, exc, emit_ok, emit, late, noret, k_end, k_skip, det_last;
	logic                        em_kind, em_last;
	logic [twap_pkg::VERD_W-1:0] em_verd;
	logic [XW-1:0]               kx;
	twap_pkg::kchk_t             chk;
	logic [T-1:0]                k_latest;

	assign n_act    = (ncnt_q < twap_pkg::CNT_W'(NODES)) ? ncnt_q : XW'(NODES);
	assign req_acc  = req.valid && req.ready;
	assign eval_acc = req_acc && (req.action == twap_pkg::ACT_EVAL);
	assign emit_ok  = !ovalid_q || rsp.ready;
	assign tmax     = node_rdata[2*T-1:T];
	assign kx       = XW'(k_q);

	// endpoint exclusion, decided on the request fields and the configuration
	assign exc = ({1'b0, req.from_index} >= n_act) || ({1'b0, req.to_index} >= n_act) ||
		({1'b0, src_q} >= n_act) || ({1'b0, snk_q} >= n_act) ||
		(req.from_index == snk_q) || (req.to_index == src_q) ||
		(req.from_index == req.to_index);

	assign k_end  = kx >= n_act;
	assign k_skip = (kx == {1'b0, tail_q}) || (kx == {1'b0, head_q}) ||
		(kx == {1'b0, src_q}) || (kx == {1'b0, snk_q});
	assign det_last = (nemit_q + KW'(1)) == ndet_q;

	assign ret   = ((arrj_q > sx(oj_q)) ? arrj_q : sx(oj_q)) + sx(sj_q) + sx(djs_q);
	assign late  = arrj_q > sx(cj_q);
	assign noret = ret > sx(tmax);

	// loads go straight into the memories
	assign node_we    = req_acc && (req.action == twap_pkg::ACT_LOAD_NODE) &&
		({1'b0, req.from_index} < XW'(NODES));
	assign node_waddr = req.from_index[IW-1:0];
	assign node_wdata = {T'(req.window_open), T'(req.window_close), T'(req.service_ticks)};
	assign dist_we    = req_acc && (req.action == twap_pkg::ACT_LOAD_DIST) &&
		({1'b0, req.from_index} < XW'(NODES)) && ({1'b0, req.to_index} < XW'(NODES));
	assign dist_waddr = daddr(req.from_index[IW-1:0], req.to_index[IW-1:0]);

	twap_ram #(.WIDTH(3 * T), .DEPTH(NODES)) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.re   (node_re),
		.raddr(node_raddr),
		.rdata(node_rdata)
	);

	twap_ram #(.WIDTH(T), .DEPTH(NODES * NODES)) u_dist_ram (
		.clk  (clk),
		.we   (dist_we),
		.waddr(dist_waddr),
		.wdata(T'(req.travel_ticks)),
		.re   (dist_re),
		.raddr(dist_raddr),
		.rdata(dist_rdata)
	);

	twap_check #(.TIME_BITS(T)) u_check (
		.oi    (oi_q),
		.ci    (ci_q),
		.si    (si_q),
		.cisi  (cisi_q),
		.oj    (oj_q),
		.ok    (ok_q),
		.ck    (ck_q),
		.sk    (sk_q),
		.dik   (dik_q),
		.dkj   (dist_rdata),
		.chk   (chk),
		.latest(k_latest)
	);

	// sequencer: next state, memory reads, emit decision
	always_comb begin
		state_d    = state_q;
		node_re    = 1'b0;
		node_raddr = '0;
		dist_re    = 1'b0;
		dist_raddr = '0;
		emit       = 1'b0;
		em_kind    = 1'b0;
		em_verd    = twap_pkg::VERD_KEPT;
		em_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (eval_acc) begin
					state_d = exc ? S_EXC : S_RD_I;
				end
			end
			S_EXC: begin
				em_verd = twap_pkg::VERD_EXCL;
				if (emit_ok) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RD_I: begin
				node_re    = 1'b1;
				node_raddr = tail_q[IW-1:0];
				dist_re    = 1'b1;
				dist_raddr = daddr(tail_q[IW-1:0], head_q[IW-1:0]);
				state_d    = S_RD_J;
			end
			S_RD_J: begin
				node_re    = 1'b1;
				node_raddr = head_q[IW-1:0];
				dist_re    = 1'b1;
				dist_raddr = daddr(head_q[IW-1:0], snk_q[IW-1:0]);
				state_d    = S_RD_S;
			end
			S_RD_S: begin
				node_re    = 1'b1;
				node_raddr = src_q[IW-1:0];
				state_d    = S_CHK;
			end
			S_CHK: begin
				em_verd = late ? twap_pkg::VERD_LATE : twap_pkg::VERD_NORET;
				if (late || noret) begin
					if (emit_ok) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_K_ISS;
				end
			end
			S_K_ISS: begin
				if (k_end) begin
					state_d = pass_q ? S_IDLE : S_VERD;
				end else if (!k_skip) begin
					node_re    = 1'b1;
					node_raddr = k_q[IW-1:0];
					dist_re    = 1'b1;
					dist_raddr = daddr(tail_q[IW-1:0], k_q[IW-1:0]);
					state_d    = S_K_MID;
				end
			end
			S_K_MID: begin
				dist_re    = 1'b1;
				dist_raddr = daddr(k_q[IW-1:0], head_q[IW-1:0]);
				state_d    = S_K_EVAL;
			end
			S_K_EVAL: begin
				if (!pass_q) begin
					em_verd = twap_pkg::VERD_PRUNED;
					if (chk.prune) begin
						if (emit_ok) begin
							emit    = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						state_d = S_K_ISS;
					end
				end else if (chk.detour) begin
					em_kind = 1'b1;
					em_last = det_last;
					if (emit_ok) begin
						emit    = 1'b1;
						state_d = det_last ? S_IDLE : S_K_ISS;
					end
				end else begin
					state_d = S_K_ISS;
				end
			end
			S_VERD: begin
				em_last = (ndet_q == '0);
				if (emit_ok) begin
					emit    = 1'b1;
					state_d = (ndet_q == '0) ? S_IDLE : S_K_ISS;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			ncnt_q   <= twap_pkg::RST_NODE_COUNT;
			src_q    <= twap_pkg::RST_SOURCE;
			snk_q    <= twap_pkg::RST_SINK;
			k_q      <= '0;
			pass_q   <= 1'b0;
			ndet_q   <= '0;
			nemit_q  <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			if (cfg.valid) begin
				case (cfg.index)
					twap_pkg::REG_NODE_COUNT: ncnt_q <= cfg.data;
					twap_pkg::REG_SOURCE:     src_q  <= cfg.data[twap_pkg::IDX_W-1:0];
					twap_pkg::REG_SINK:       snk_q  <= cfg.data[twap_pkg::IDX_W-1:0];
					default: ;
				endcase
			end
			// scan counters
			case (state_q)
				S_CHK: begin
					k_q     <= '0;
					pass_q  <= 1'b0;
					ndet_q  <= '0;
					nemit_q <= '0;
				end
				S_K_ISS: begin
					if (!k_end && k_skip) begin
						k_q <= k_q + KW'(1);
					end
				end
				S_K_EVAL: begin
					if (state_d == S_K_ISS) begin
						k_q <= k_q + KW'(1);
					end
					if (!pass_q && !chk.prune && chk.detour) begin
						ndet_q <= ndet_q + KW'(1);
					end
					if (pass_q && emit) begin
						nemit_q <= nemit_q + KW'(1);
					end
				end
				S_VERD: begin
					if (emit) begin
						k_q    <= '0;
						pass_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// operand capture from the request and from memory read data
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				tail_q <= req.from_index;
				head_q <= req.to_index;
			end
			S_RD_J: begin
				{oi_q, ci_q, si_q} <= node_rdata;
				dij_q              <= dist_rdata;
			end
			S_RD_S: begin
				{oj_q, cj_q, sj_q} <= node_rdata;
				djs_q              <= dist_rdata;
				cisi_q             <= {1'b0, ci_q} + {1'b0, si_q};
				arrj_q             <= sx(oi_q) + sx(si_q) + sx(dij_q);
			end
			S_K_MID: begin
				{ok_q, ck_q, sk_q} <= node_rdata;
				dik_q              <= dist_rdata;
			end
			default: ;
		endcase
		// arc held with the item so that a waiting item keeps its fields
		if (emit) begin
			okind_q   <= em_kind;
			overd_q   <= em_verd;
			olast_q   <= em_last;
			otail_q   <= tail_q;
			ohead_q   <= head_q;
			otravel_q <= (state_q == S_EXC) ? '0 : twap_pkg::TICK_W'(dij_q);
			onode_q   <= em_kind ? twap_pkg::IDX_W'(k_q) : '0;
			olate_q   <= em_kind ? twap_pkg::TICK_W'(k_latest) : '0;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid               = ovalid_q;
	assign rsp.record_kind         = okind_q;
	assign rsp.arc_tail            = otail_q;
	assign rsp.arc_head            = ohead_q;
	assign rsp.verdict             = overd_q;
	assign rsp.arc_travel          = otravel_q;
	assign rsp.detour_node         = onode_q;
	assign rsp.detour_latest_start = olate_q;
	assign rsp.last_record         = olast_q;

	// checks
	`TWAP_ASSERT_IMP(a_det_count, clk, arst_n, emit && em_kind, nemit_q < ndet_q, "detour overrun")
	`TWAP_ASSERT_NXT(a_last_idle, clk, arst_n, emit && em_last, state_q == S_IDLE, "busy after last")
	`TWAP_ASSERT_NXT(a_eval_busy, clk, arst_n, eval_acc, !req.ready, "eval not taken")
	`TWAP_ASSERT_IMP(a_pass1_cnt, clk, arst_n, (state_q == S_K_ISS) && pass_q, ndet_q != '0, "empty detour pass")
endmodule
